/* hdl/bps_pkg.sv */
package bps_pkg;
   localparam int PIX_BITS = 12;
   localparam int LVL_BITS = 8;
   localparam int NUM_REGS = 8;
   localparam int IDX_BITS = 3;
   localparam int NUM_PIX = 9;
   localparam int PIX_CNT_BITS = 4;

   localparam logic [IDX_BITS-1:0] REG_P0_X = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_P0_Y = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_P1_X = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_P1_Y = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_P2_X = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_P2_Y = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_P3_X = 3'd6;
   localparam logic [IDX_BITS-1:0] REG_P3_Y = 3'd7;

   typedef struct packed {
      logic [PIX_BITS-1:0] ix;
      logic [PIX_BITS-1:0] iy;
      logic [15:0]         fx;
      logic [15:0]         fy;
   } point_type;
endpackage

/* hdl/bps_lerp.sv */
module bps_lerp #(
   parameter int W = 26,
   parameter int F = 16
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [F-1:0] t,
   output logic [W-1:0] y_ff
);
   logic [W+F:0] acc;
   logic [F:0]   one_minus;
   always_comb begin
      one_minus = (F+1)'(1) << F;
      one_minus = one_minus - {1'b0, t};
      acc = ((W+F+1)'(a) * (W+F+1)'(one_minus)) + ((W+F+1)'(b) * (W+F+1)'(t))
            + ((W+F+1)'(1) << (F-1));
   end
   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= acc[F +: W];
      end
   end
endmodule

/* hdl/bps_front.sv */
module bps_front #(
   parameter int COORD_BITS = 10,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [T_FRAC_BITS-1:0] in_t,
   input  logic [COORD_BITS-1:0]  px_c [4],
   input  logic [COORD_BITS-1:0]  py_c [4],
   output logic                   out_valid,
   input  logic                   out_ready,
   output bps_pkg::point_type     out_point
);
   import bps_pkg::*;
   localparam int W = COORD_BITS + T_FRAC_BITS;
   localparam int E = (T_FRAC_BITS > 16) ? 16 : T_FRAC_BITS;

   logic [2:0] v_ff;
   logic [T_FRAC_BITS-1:0] t_ff [2];
   logic en;
   logic [W-1:0] ax [6];
   logic [W-1:0] ay [6];
   logic [W-1:0] sx [4];
   logic [W-1:0] sy [4];

   assign en = !v_ff[2] || out_ready;
   assign in_ready = en;
   assign out_valid = v_ff[2];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sx[k] = {px_c[k], {T_FRAC_BITS{1'b0}}};
         sy[k] = {py_c[k], {T_FRAC_BITS{1'b0}}};
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_s1
      bps_lerp #(.W(W), .F(T_FRAC_BITS)) u_x (.clock, .en, .a(sx[k]), .b(sx[k+1]),
         .t(in_t), .y_ff(ax[k]));
      bps_lerp #(.W(W), .F(T_FRAC_BITS)) u_y (.clock, .en, .a(sy[k]), .b(sy[k+1]),
         .t(in_t), .y_ff(ay[k]));
   end
   for (genvar k = 0; k < 2; k++) begin : g_s2
      bps_lerp #(.W(W), .F(T_FRAC_BITS)) u_x (.clock, .en, .a(ax[k]), .b(ax[k+1]),
         .t(t_ff[0]), .y_ff(ax[3+k]));
      bps_lerp #(.W(W), .F(T_FRAC_BITS)) u_y (.clock, .en, .a(ay[k]), .b(ay[k+1]),
         .t(t_ff[0]), .y_ff(ay[3+k]));
   end
   bps_lerp #(.W(W), .F(T_FRAC_BITS)) u_x3 (.clock, .en, .a(ax[3]), .b(ax[4]),
      .t(t_ff[1]), .y_ff(ax[5]));
   bps_lerp #(.W(W), .F(T_FRAC_BITS)) u_y3 (.clock, .en, .a(ay[3]), .b(ay[4]),
      .t(t_ff[1]), .y_ff(ay[5]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
      if (en) begin
         t_ff[0] <= in_t;
         t_ff[1] <= t_ff[0];
      end
   end

   always_comb begin
      out_point.ix = PIX_BITS'(ax[5][W-1:T_FRAC_BITS]);
      out_point.iy = PIX_BITS'(ay[5][W-1:T_FRAC_BITS]);
      out_point.fx = 16'(ax[5][T_FRAC_BITS-1 -: E]);
      out_point.fy = 16'(ay[5][T_FRAC_BITS-1 -: E]);
   end
endmodule

/* hdl/bps_queue.sv */
module bps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bps_pkg::point_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bps_pkg::point_type out_data
);
   import bps_pkg::*;
   point_type mem_ff [2];
   logic [1:0] cnt_ff;
   logic wp_ff, rp_ff;
   logic push, pop;
   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

/* hdl/bps_back.sv */
module bps_back #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  bps_pkg::point_type            in_point,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [bps_pkg::PIX_BITS-1:0]  out_x,
   output logic [bps_pkg::PIX_BITS-1:0]  out_y,
   output logic [bps_pkg::LVL_BITS-1:0]  out_lvl,
   output logic                          out_last
);
   import bps_pkg::*;
   localparam int E = (T_FRAC_BITS > 16) ? 16 : T_FRAC_BITS;
   localparam int DW = E + 3;
   localparam int SW = 2 * DW;
   localparam int SH = 2 * E + 3;
   localparam int NW = SW + 17;
   localparam int QW = NW - SH;

   // stage A: pick neighbour, square offsets
   logic [PIX_CNT_BITS-1:0] idx_ff;
   logic [1:0] di_ff, dj_ff;
   logic a_ok;
   logic       b_v_ff, c_v_ff, o_v_ff;
   logic       b_last_ff, c_last_ff, b_ctr_ff, c_ctr_ff;
   logic [PIX_BITS-1:0] b_x_ff, b_y_ff, c_x_ff, c_y_ff;
   logic signed [DW-1:0] dx, dy;
   logic signed [SW-1:0] dx_w, dy_w;
   logic [SW-1:0] b_s_ff;
   logic [NW-1:0] n_w;
   logic [QW-1:0] c_q_ff;
   logic [255:0]  below;
   logic [8:0]    k_w;
   logic stall;
   logic [PIX_BITS-1:0] di_ext, dj_ext;

   assign stall = o_v_ff && !out_ready;
   assign a_ok = in_valid && !stall;
   assign in_ready = a_ok && idx_ff == PIX_CNT_BITS'(NUM_PIX - 1);

   always_comb begin
      dx = DW'($signed({1'b0, di_ff}) - 2'sd1) * ($signed(DW'(1)) <<< E)
           + ($signed(DW'(1)) <<< (E-1)) - $signed({3'b0, in_point.fx[E-1:0]});
      dy = DW'($signed({1'b0, dj_ff}) - 2'sd1) * ($signed(DW'(1)) <<< E)
           + ($signed(DW'(1)) <<< (E-1)) - $signed({3'b0, in_point.fy[E-1:0]});
      dx_w = SW'(dx);
      dy_w = SW'(dy);
      di_ext = PIX_BITS'({1'b0, di_ff}) - PIX_BITS'(1);
      dj_ext = PIX_BITS'({1'b0, dj_ff}) - PIX_BITS'(1);
      n_w = NW'(b_s_ff) * NW'(65025) + ((NW'(1) << SH) - NW'(1));
      for (int i = 0; i < 256; i++) begin
         below[i] = (QW+1)'(i) * (QW+1)'(i) < (QW+1)'(c_q_ff);
      end
      k_w = 9'($countones(below));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         di_ff <= 2'd0;
         dj_ff <= 2'd0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (!stall) begin
         b_v_ff <= a_ok;
         c_v_ff <= b_v_ff;
         o_v_ff <= c_v_ff;
         if (a_ok) begin
            if (idx_ff == PIX_CNT_BITS'(NUM_PIX - 1)) begin
               idx_ff <= '0;
               di_ff <= 2'd0;
               dj_ff <= 2'd0;
            end else begin
               idx_ff <= idx_ff + PIX_CNT_BITS'(1);
               if (dj_ff == 2'd2) begin
                  dj_ff <= 2'd0;
                  di_ff <= di_ff + 2'd1;
               end else begin
                  dj_ff <= dj_ff + 2'd1;
               end
            end
         end
      end
      if (!stall) begin
         b_s_ff <= SW'($unsigned(dx_w * dx_w)) + SW'($unsigned(dy_w * dy_w));
         b_x_ff <= in_point.ix + di_ext;
         b_y_ff <= in_point.iy + dj_ext;
         b_last_ff <= idx_ff == PIX_CNT_BITS'(NUM_PIX - 1);
         b_ctr_ff <= di_ff == 2'd1 && dj_ff == 2'd1;
         c_q_ff <= n_w[NW-1:SH];
         c_x_ff <= b_x_ff;
         c_y_ff <= b_y_ff;
         c_last_ff <= b_last_ff;
         c_ctr_ff <= b_ctr_ff;
         out_x <= c_x_ff;
         out_y <= c_y_ff;
         out_last <= c_last_ff;
         out_lvl <= c_ctr_ff ? 8'd255 : (k_w >= 9'd255 ? 8'd0 : 8'(9'd255 - k_w));
      end
   end
   assign out_valid = o_v_ff;
endmodule

/* hdl/bezier_point_antialiased_splat_unit.sv */
// Evaluates a cubic Bezier curve at req_t and emits the 3x3 splat around the point,
// nine results per item, column offset outer and row offset inner, rsp_last on the
// ninth. The output stage emits one pixel per cycle while rsp_ready is high, and a
// new item can be taken before earlier ones are through; each result passes through
// the three interpolation stages, the queue and the three distance stages. The user
// must write control points on the csr_ port only while idle; nothing enforces it.
module bezier_point_antialiased_splat_unit #(
   parameter int COORD_BITS = 10,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [T_FRAC_BITS-1:0] req_t,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [11:0]     rsp_pixel_x,
   output logic signed [11:0]     rsp_pixel_y,
   output logic [7:0]             rsp_intensity,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [COORD_BITS-1:0]  csr_data
);
   import bps_pkg::*;
   logic [COORD_BITS-1:0] px_ff [4];
   logic [COORD_BITS-1:0] py_ff [4];
   logic f_v, f_r, b_v, b_r;
   point_type f_p, b_p;
   logic [PIX_BITS-1:0] ox, oy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            px_ff[k] <= '0;
            py_ff[k] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_P0_X: px_ff[0] <= csr_data;
            REG_P0_Y: py_ff[0] <= csr_data;
            REG_P1_X: px_ff[1] <= csr_data;
            REG_P1_Y: py_ff[1] <= csr_data;
            REG_P2_X: px_ff[2] <= csr_data;
            REG_P2_Y: py_ff[2] <= csr_data;
            REG_P3_X: px_ff[3] <= csr_data;
            REG_P3_Y: py_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   bps_front #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready), .in_t(req_t),
      .px_c(px_ff), .py_c(py_ff), .out_valid(f_v), .out_ready(f_r), .out_point(f_p));

   bps_queue u_queue (.clock, .reset, .in_valid(f_v), .in_ready(f_r), .in_data(f_p),
      .out_valid(b_v), .out_ready(b_r), .out_data(b_p));

   bps_back #(.T_FRAC_BITS(T_FRAC_BITS)) u_back (.clock, .reset, .in_valid(b_v),
      .in_ready(b_r), .in_point(b_p), .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_x(ox), .out_y(oy), .out_lvl(rsp_intensity), .out_last(rsp_last));

   assign rsp_pixel_x = $signed(ox);
   assign rsp_pixel_y = $signed(oy);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_last))
      else $error("result changed under stall");
   a_ctr: assert property (@(posedge clock) disable iff (reset)
      u_back.c_v_ff && u_back.c_ctr_ff && !u_back.stall |=> rsp_intensity == 8'd255)
      else $error("centre pixel not full intensity");
endmodule

/* verif/bezier_point_antialiased_splat_unit_test.sv */
module bezier_point_antialiased_splat_unit_test;
   import bps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 10;
   localparam int T_FRAC_BITS = 16;
   localparam int CLOCK_PERIOD = 12;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic signed [PIX_BITS-1:0] pixel_x;
      logic signed [PIX_BITS-1:0] pixel_y;
      logic [LVL_BITS-1:0]        intensity;
      logic                       last;
   } splat_pixel_t;

   typedef struct {
      logic [T_FRAC_BITS-1:0] t;
      bit                     typed_in;
      logic signed [PIX_BITS-1:0] centre_x;
      logic signed [PIX_BITS-1:0] centre_y;
   } stim_row_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [T_FRAC_BITS-1:0] req_t;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic signed [11:0]     rsp_pixel_x;
   logic signed [11:0]     rsp_pixel_y;
   logic [7:0]             rsp_intensity;
   logic                   rsp_last;
   logic                   csr_we;
   logic [2:0]             csr_index;
   logic [COORD_BITS-1:0]  csr_data;

   logic [COORD_BITS-1:0] ctrl_pts [NUM_REGS];
   splat_pixel_t          pending_pixels [$];
   int                    error_count;
   int                    send_idle_pct;
   int                    recv_idle_pct;

   bezier_point_antialiased_splat_unit #(
      .COORD_BITS(COORD_BITS),
      .T_FRAC_BITS(T_FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_t(req_t),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_intensity(rsp_intensity),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(30_000_000);
      $display("bezier_point_antialiased_splat_unit_test failed");
      $finish;
   end

   function automatic longint unsigned lerp_q(longint unsigned a, longint unsigned b,
                                              longint unsigned t);
      longint unsigned one;
      longint unsigned acc;
      one = 64'd1 << T_FRAC_BITS;
      acc = a * (one - t) + b * t;
      return (acc + (one >> 1)) >> T_FRAC_BITS;
   endfunction

   function automatic longint unsigned curve_axis(int axis, longint unsigned t);
      longint unsigned v [4];
      for (int k = 0; k < 4; k++) v[k] = longint'(ctrl_pts[2 * k + axis]) << T_FRAC_BITS;
      for (int n = 3; n > 0; n--)
         for (int k = 0; k < n; k++) v[k] = lerp_q(v[k], v[k + 1], t);
      return v[0];
   endfunction

   function automatic int falloff_level(int di, int dj, longint fx, longint fy);
      longint dx;
      longint dy;
      longint unsigned q;
      longint unsigned k;
      dx = di * 65536 + 32768 - fx;
      dy = dj * 65536 + 32768 - fy;
      q = (65025 * longint'(dx * dx + dy * dy) + ((64'd1 << 35) - 1)) >> 35;
      k = 0;
      while (k * k < q) k++;
      return (k >= 255) ? 0 : 255 - int'(k);
   endfunction

   task automatic predict_splat(input logic [T_FRAC_BITS-1:0] t);
      longint unsigned px;
      longint unsigned py;
      longint unsigned fx;
      longint unsigned fy;
      splat_pixel_t    p;
      int              r;
      px = curve_axis(0, t);
      py = curve_axis(1, t);
      fx = px & 64'hFFFF;
      fy = py & 64'hFFFF;
      r = 0;
      for (int di = -1; di <= 1; di++) begin
         for (int dj = -1; dj <= 1; dj++) begin
            p.pixel_x = PIX_BITS'((px >> T_FRAC_BITS) + di);
            p.pixel_y = PIX_BITS'((py >> T_FRAC_BITS) + dj);
            p.intensity = (di == 0 && dj == 0) ? 8'd255 : LVL_BITS'(falloff_level(di, dj, fx, fy));
            p.last = (r == 8);
            pending_pixels.push_back(p);
            r++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      splat_pixel_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_pixel_x, 0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.pixel_x) report_mismatch("pixel_x", rsp_pixel_x, want.pixel_x);
            if (rsp_pixel_y !== want.pixel_y) report_mismatch("pixel_y", rsp_pixel_y, want.pixel_y);
            if (rsp_intensity !== want.intensity)
               report_mismatch("intensity", rsp_intensity, want.intensity);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_csr(input logic [2:0] index, input logic [COORD_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      ctrl_pts[index] = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_t(input logic [T_FRAC_BITS-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_t <= t;
      predict_splat(t);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_curve(input logic [COORD_BITS-1:0] v [8]);
      write_csr(REG_P0_X, v[0]);
      write_csr(REG_P0_Y, v[1]);
      write_csr(REG_P1_X, v[2]);
      write_csr(REG_P1_Y, v[3]);
      write_csr(REG_P2_X, v[4]);
      write_csr(REG_P2_Y, v[5]);
      write_csr(REG_P3_X, v[6]);
      write_csr(REG_P3_Y, v[7]);
   endtask

   initial begin
      stim_row_t             rows [$];
      stim_row_t             row;
      logic [COORD_BITS-1:0] pts [8];
      splat_pixel_t          centre;

      error_count = 0;
      send_idle_pct = 15;
      recv_idle_pct = 53;
      reset = 1'b1;
      req_valid = 1'b0;
      req_t = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all control points at the origin: centre pixel sits at (0,0)
      rows.push_back('{16'h0000, 1'b1, 12'sd0, 12'sd0});
      rows.push_back('{16'hFFFF, 1'b1, 12'sd0, 12'sd0});
      foreach (rows[i]) begin
         send_t(rows[i].t);
         centre = pending_pixels[pending_pixels.size() - 5];
         if (centre.pixel_x !== rows[i].centre_x || centre.pixel_y !== rows[i].centre_y
             || centre.intensity !== 8'd255)
            report_mismatch("directed centre", centre.pixel_x, rows[i].centre_x);
      end
      drain();

      // top corner: neighbours fall past the window edge
      pts = '{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF};
      set_curve(pts);
      rows.delete();
      rows.push_back('{16'h0000, 1'b1, 12'sd1023, 12'sd1023});
      rows.push_back('{16'h8000, 1'b1, 12'sd1023, 12'sd1023});
      rows.push_back('{16'hFFFF, 1'b1, 12'sd1023, 12'sd1023});
      foreach (rows[i]) send_t(rows[i].t);
      drain();

      // sweep across the full window to exercise fractions
      pts = '{10'h000, 10'h3FF, 10'h155, 10'h000, 10'h2AA, 10'h3FF, 10'h3FF, 10'h000};
      set_curve(pts);
      foreach (row.t[i]) send_t(T_FRAC_BITS'(1) << i);
      send_t(16'h5555);
      send_t(16'hAAAA);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 15 : 0;
         foreach (pts[i]) pts[i] = COORD_BITS'($urandom);
         set_curve(pts);
         for (int n = 0; n < 34; n++) begin
            send_t(T_FRAC_BITS'($urandom));
            if (n == 17) begin
               req_valid <= 1'b0;
               while (pending_pixels.size() != 0) @(negedge clock);
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("bezier_point_antialiased_splat_unit_test passed");
      end else begin
         $display("bezier_point_antialiased_splat_unit_test failed");
      end
      $finish;
   end
endmodule

/* bezier_point_antialiased_splat_unit.f */
hdl/bps_pkg.sv
hdl/bps_lerp.sv
hdl/bps_front.sv
hdl/bps_queue.sv
hdl/bps_back.sv
hdl/bezier_point_antialiased_splat_unit.sv
verif/bezier_point_antialiased_splat_unit_test.sv
